@@ rtl/blr_pkg.sv @@
package blr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int ADDR_W         = 26;
  localparam int PITCH_W        = 15;
  localparam int BPP_W          = 3;
  localparam int COLOR_W        = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = PITCH_W;

  localparam logic [PITCH_W-1:0] PITCH_RST = PITCH_W'(3072);
  localparam logic [BPP_W-1:0]   BPP_RST   = BPP_W'(3);
  localparam logic [BPP_W-1:0]   BPP_ALPHA = BPP_W'(4);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BPP       = CFG_IDX_W'(1);

  typedef struct packed {
    logic valid;
    logic last;
  } blr_ctl_t;

endpackage

@@ rtl/blr_step.sv @@
module blr_step #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [COORD_BITS-1:0]       in_start_x,
  input  logic [COORD_BITS-1:0]       in_start_y,
  input  logic [COORD_BITS-1:0]       in_end_x,
  input  logic [COORD_BITS-1:0]       in_end_y,
  input  logic [blr_pkg::COLOR_W-1:0] in_line_color,
  input  logic                        take,
  output blr_pkg::blr_ctl_t           pix_ctl,
  output logic [COORD_BITS-1:0]       pix_x,
  output logic [COORD_BITS-1:0]       pix_y,
  output logic [blr_pkg::COLOR_W-1:0] pix_color
);

  localparam int ERR_W = COORD_BITS + 2;
  localparam int E2_W  = COORD_BITS + 3;

  logic [COORD_BITS-1:0]       cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0]       tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [COORD_BITS-1:0]       span_x_r, span_x_nxt, span_y_r, span_y_nxt;
  logic                        neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic signed [ERR_W-1:0]     err_r, err_nxt;
  logic [blr_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic                        busy_r, busy_nxt;

  blr_pkg::blr_ctl_t           ctl_r, ctl_nxt;
  logic [COORD_BITS-1:0]       px_r, px_nxt, py_r, py_nxt;
  logic [blr_pkg::COLOR_W-1:0] pcol_r, pcol_nxt;

  logic                        accept;
  logic                        slot_free;
  logic signed [E2_W-1:0]      e2;
  logic                        move_x, move_y;
  logic [COORD_BITS-1:0]       step_x, step_y;
  logic [COORD_BITS-1:0]       dx, dy;

  assign slot_free = !ctl_r.valid || take;
  assign in_stall  = !slot_free;
  assign accept    = in_valid && slot_free;

  assign dx = (in_start_x > in_end_x) ? in_start_x - in_end_x : in_end_x - in_start_x;
  assign dy = (in_start_y > in_end_y) ? in_start_y - in_end_y : in_end_y - in_start_y;

  assign e2     = {err_r, 1'b0};
  assign move_x = e2 > -$signed({3'b000, span_y_r});
  assign move_y = e2 < $signed({3'b000, span_x_r});
  assign step_x = neg_x_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
  assign step_y = neg_y_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    span_x_nxt = span_x_r;
    span_y_nxt = span_y_r;
    neg_x_nxt  = neg_x_r;
    neg_y_nxt  = neg_y_r;
    err_nxt    = err_r;
    color_nxt  = color_r;
    busy_nxt   = busy_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    pcol_nxt   = pcol_r;
    ctl_nxt    = ctl_r;
    if (take) begin
      ctl_nxt.valid = 1'b0;
    end
    if (accept) begin
      ctl_nxt.valid = 1'b0;
      if (in_opcode == blr_pkg::OP_START) begin
        cur_x_nxt  = in_start_x;
        cur_y_nxt  = in_start_y;
        tgt_x_nxt  = in_end_x;
        tgt_y_nxt  = in_end_y;
        color_nxt  = in_line_color;
        span_x_nxt = dx;
        span_y_nxt = dy;
        neg_x_nxt  = !(in_start_x < in_end_x);
        neg_y_nxt  = !(in_start_y < in_end_y);
        err_nxt    = $signed({2'b00, dx}) - $signed({2'b00, dy});
        busy_nxt   = (in_start_x != in_end_x) || (in_start_y != in_end_y);
      end else if (busy_r) begin
        px_nxt   = cur_x_r;
        py_nxt   = cur_y_r;
        pcol_nxt = color_r;
        err_nxt  = err_r
                 - (move_x ? $signed({2'b00, span_y_r}) : ERR_W'(0))
                 + (move_y ? $signed({2'b00, span_x_r}) : ERR_W'(0));
        if (move_x) begin
          cur_x_nxt = step_x;
        end
        if (move_y) begin
          cur_y_nxt = step_y;
        end
        ctl_nxt.valid = 1'b1;
        ctl_nxt.last  = (cur_x_nxt == tgt_x_r) && (cur_y_nxt == tgt_y_r);
        if (ctl_nxt.last) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ctl_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    tgt_x_r  <= tgt_x_nxt;
    tgt_y_r  <= tgt_y_nxt;
    span_x_r <= span_x_nxt;
    span_y_r <= span_y_nxt;
    neg_x_r  <= neg_x_nxt;
    neg_y_r  <= neg_y_nxt;
    err_r    <= err_nxt;
    color_r  <= color_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    pcol_r   <= pcol_nxt;
  end

  assign pix_ctl   = ctl_r;
  assign pix_x     = px_r;
  assign pix_y     = py_r;
  assign pix_color = pcol_r;

endmodule

@@ rtl/blr_addr.sv @@
module blr_addr #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  blr_pkg::blr_ctl_t           pix_ctl,
  input  logic [COORD_BITS-1:0]       pix_x,
  input  logic [COORD_BITS-1:0]       pix_y,
  input  logic [blr_pkg::COLOR_W-1:0] pix_color,
  input  logic [blr_pkg::PITCH_W-1:0] row_pitch,
  input  logic [blr_pkg::BPP_W-1:0]   bytes_per_pixel,
  output logic                        take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [COORD_BITS-1:0]       out_pixel_x,
  output logic [COORD_BITS-1:0]       out_pixel_y,
  output logic [blr_pkg::ADDR_W-1:0]  out_pixel_address,
  output logic [blr_pkg::COLOR_W-1:0] out_pixel_color,
  output logic                        out_write_alpha,
  output logic                        out_last_pixel
);

  localparam int PY_W  = COORD_BITS + blr_pkg::PITCH_W;
  localparam int PX_W  = COORD_BITS + blr_pkg::BPP_W;
  localparam int SUM_W = ((PY_W > blr_pkg::ADDR_W) ? PY_W : blr_pkg::ADDR_W) + 1;

  logic                        valid_r, valid_nxt;
  logic [COORD_BITS-1:0]       x_r, y_r;
  logic [blr_pkg::ADDR_W-1:0]  addr_r;
  logic [blr_pkg::COLOR_W-1:0] color_r;
  logic                        alpha_r, last_r;

  logic [PY_W-1:0]  prod_y;
  logic [PX_W-1:0]  prod_x;
  logic [SUM_W-1:0] addr_sum;

  assign take      = !valid_r || !out_stall;
  assign valid_nxt = take ? pix_ctl.valid : valid_r;

  assign prod_y   = PY_W'(pix_y) * PY_W'(row_pitch);
  assign prod_x   = PX_W'(pix_x) * PX_W'(bytes_per_pixel);
  assign addr_sum = SUM_W'(prod_y) + SUM_W'(prod_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pix_ctl.valid) begin
      x_r     <= pix_x;
      y_r     <= pix_y;
      addr_r  <= addr_sum[blr_pkg::ADDR_W-1:0];
      color_r <= pix_color;
      alpha_r <= (bytes_per_pixel == blr_pkg::BPP_ALPHA);
      last_r  <= pix_ctl.last;
    end
  end

  assign out_valid         = valid_r;
  assign out_pixel_x       = x_r;
  assign out_pixel_y       = y_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = color_r;
  assign out_write_alpha   = alpha_r;
  assign out_last_pixel    = last_r;

endmodule

@@ rtl/bresenham_line_rasterizer_core.sv @@
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_stall  | opcode, endpoints, line colour
// out      | output    | out_valid / out_stall | pixel x, y, address, colour, flags
// cfg      | input     | cfg_wr_en            | cfg_index, cfg_wdata
// one item is taken per clock while in_stall is low; a pixel goes from its step transfer
// to the pixel register, then the output register; the bresenham state updates in the
// transfer cycle, the address multiply sits before the output register
// rst_n is synchronous; it clears the line-active flag and both pipeline valid bits
// out_stall holds the output register; the middle pixel register still takes an item
// when empty, so in_stall only rises with both stages full
module bresenham_line_rasterizer_core #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [COORD_BITS-1:0]          in_start_x,
  input  logic [COORD_BITS-1:0]          in_start_y,
  input  logic [COORD_BITS-1:0]          in_end_x,
  input  logic [COORD_BITS-1:0]          in_end_y,
  input  logic [blr_pkg::COLOR_W-1:0]    in_line_color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COORD_BITS-1:0]          out_pixel_x,
  output logic [COORD_BITS-1:0]          out_pixel_y,
  output logic [blr_pkg::ADDR_W-1:0]     out_pixel_address,
  output logic [blr_pkg::COLOR_W-1:0]    out_pixel_color,
  output logic                           out_write_alpha,
  output logic                           out_last_pixel,
  input  logic                           cfg_wr_en,
  input  logic [blr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [blr_pkg::PITCH_W-1:0] pitch_r, pitch_nxt;
  logic [blr_pkg::BPP_W-1:0]   bpp_r, bpp_nxt;

  blr_pkg::blr_ctl_t           pix_ctl;
  logic [COORD_BITS-1:0]       pix_x, pix_y;
  logic [blr_pkg::COLOR_W-1:0] pix_color;
  logic                        take;

  always_comb begin
    pitch_nxt = pitch_r;
    bpp_nxt   = bpp_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        blr_pkg::CFG_ROW_PITCH: pitch_nxt = cfg_wdata[blr_pkg::PITCH_W-1:0];
        blr_pkg::CFG_BPP:       bpp_nxt   = cfg_wdata[blr_pkg::BPP_W-1:0];
        default: begin
          pitch_nxt = pitch_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= blr_pkg::PITCH_RST;
      bpp_r   <= blr_pkg::BPP_RST;
    end else begin
      pitch_r <= pitch_nxt;
      bpp_r   <= bpp_nxt;
    end
  end

  blr_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .in_line_color(in_line_color),
    .take         (take),
    .pix_ctl      (pix_ctl),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .pix_color    (pix_color)
  );

  blr_addr #(
    .COORD_BITS(COORD_BITS)
  ) u_addr (
    .clk              (clk),
    .rst_n            (rst_n),
    .pix_ctl          (pix_ctl),
    .pix_x            (pix_x),
    .pix_y            (pix_y),
    .pix_color        (pix_color),
    .row_pitch        (pitch_r),
    .bytes_per_pixel  (bpp_r),
    .take             (take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_address(out_pixel_address),
    .out_pixel_color  (out_pixel_color),
    .out_write_alpha  (out_write_alpha),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

@@ rtl/blr_checker.sv @@
module blr_checker #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [COORD_BITS-1:0]         out_pixel_x,
  input logic [COORD_BITS-1:0]         out_pixel_y,
  input logic [blr_pkg::ADDR_W-1:0]    out_pixel_address,
  input logic                          out_last_pixel
);

  // a held result keeps its position, address and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_pixel_address) && $stable(out_last_pixel))
    else $error("stalled result changed");

  // with the output register empty the input side must be open
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst_n) == 1'b0 |-> !out_valid)
    else $error("result valid straight after reset");

  // a result on an empty output comes from an earlier input transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("spurious result");

endmodule

bind bresenham_line_rasterizer_core blr_checker #(
  .COORD_BITS(COORD_BITS)
) u_blr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pixel_x      (out_pixel_x),
  .out_pixel_y      (out_pixel_y),
  .out_pixel_address(out_pixel_address),
  .out_last_pixel   (out_last_pixel)
);

@@ tb/sv/bresenham_line_rasterizer_core_tb.sv @@
module bresenham_line_rasterizer_core_tb;

  localparam int CW = blr_pkg::COORD_BITS_DEF;
  localparam int ERR_W = CW + 2;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [CW-1:0]               x;
    logic [CW-1:0]               y;
    logic [blr_pkg::ADDR_W-1:0]  addr;
    logic [blr_pkg::COLOR_W-1:0] color;
    logic                        alpha;
    logic                        last;
  } pixel_t;

  typedef struct {
    logic                        op;
    logic [CW-1:0]               sx;
    logic [CW-1:0]               sy;
    logic [CW-1:0]               ex;
    logic [CW-1:0]               ey;
    logic [blr_pkg::COLOR_W-1:0] color;
    bit                          typed;
    pixel_t                      pix;
  } row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_opcode = blr_pkg::OP_START;
  logic [CW-1:0]                  in_start_x = '0;
  logic [CW-1:0]                  in_start_y = '0;
  logic [CW-1:0]                  in_end_x = '0;
  logic [CW-1:0]                  in_end_y = '0;
  logic [blr_pkg::COLOR_W-1:0]    in_line_color = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [CW-1:0]                  out_pixel_x;
  logic [CW-1:0]                  out_pixel_y;
  logic [blr_pkg::ADDR_W-1:0]     out_pixel_address;
  logic [blr_pkg::COLOR_W-1:0]    out_pixel_color;
  logic                           out_write_alpha;
  logic                           out_last_pixel;
  logic                           cfg_wr_en = 1'b0;
  logic [blr_pkg::CFG_IDX_W-1:0]  cfg_index = blr_pkg::CFG_ROW_PITCH;
  logic [blr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // raster state mirrored by the predictor
  logic [CW-1:0]               pos_x = '0, pos_y = '0, goal_x = '0, goal_y = '0;
  logic [CW-1:0]               dist_x = '0, dist_y = '0;
  logic                        neg_x = 1'b0, neg_y = 1'b0;
  logic signed [ERR_W-1:0]     err = '0;
  logic [blr_pkg::COLOR_W-1:0] held_color = '0;
  logic                        line_busy = 1'b0;
  logic [blr_pkg::PITCH_W-1:0] pitch_reg = blr_pkg::PITCH_RST;
  logic [blr_pkg::BPP_W-1:0]   bpp_reg = blr_pkg::BPP_RST;

  pixel_t pending_pixels[$];
  bit     row_typed = 1'b0;
  pixel_t row_pix = '0;
  int     error_count = 0;
  int     quiet_cycles = 0;
  int     burst_left = 0;
  int     items_done = 0;
  int     stall_mode = 0;
  int     stall_left = 0;

  bresenham_line_rasterizer_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_line_color     (in_line_color),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_write_alpha   (out_write_alpha),
    .out_last_pixel    (out_last_pixel),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    if (error_count < 50) $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic raster_apply(input logic op, input logic [CW-1:0] sx, sy, ex, ey,
                              input logic [blr_pkg::COLOR_W-1:0] col,
                              output bit emits, output pixel_t pix);
    int         e2;
    logic [63:0] wide;
    emits = 1'b0;
    pix = '0;
    if (op == blr_pkg::OP_START) begin
      pos_x = sx;
      pos_y = sy;
      goal_x = ex;
      goal_y = ey;
      held_color = col;
      dist_x = (sx > ex) ? sx - ex : ex - sx;
      dist_y = (sy > ey) ? sy - ey : ey - sy;
      neg_x = !(sx < ex);
      neg_y = !(sy < ey);
      err = ERR_W'(int'(dist_x) - int'(dist_y));
      line_busy = (sx != ex) || (sy != ey);
    end else if (line_busy) begin
      pix.x = pos_x;
      pix.y = pos_y;
      e2 = 2 * int'(err);
      if (e2 > -int'(dist_y)) begin
        err = ERR_W'(int'(err) - int'(dist_y));
        pos_x = neg_x ? pos_x - CW'(1) : pos_x + CW'(1);
      end
      if (e2 < int'(dist_x)) begin
        err = ERR_W'(int'(err) + int'(dist_x));
        pos_y = neg_y ? pos_y - CW'(1) : pos_y + CW'(1);
      end
      pix.last = (pos_x == goal_x) && (pos_y == goal_y);
      if (pix.last) line_busy = 1'b0;
      wide = 64'(pix.y) * 64'(pitch_reg) + 64'(pix.x) * 64'(bpp_reg);
      pix.addr = wide[blr_pkg::ADDR_W-1:0];
      pix.color = held_color;
      pix.alpha = (bpp_reg == blr_pkg::BPP_ALPHA);
      emits = 1'b1;
    end
  endtask

  always @(posedge clk) begin : monitor
    bit     emits;
    pixel_t pix;
    pixel_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          blr_pkg::CFG_ROW_PITCH: pitch_reg = cfg_wdata[blr_pkg::PITCH_W-1:0];
          blr_pkg::CFG_BPP:       bpp_reg = cfg_wdata[blr_pkg::BPP_W-1:0];
          default:                ;
        endcase
      end
      if (in_valid && !in_stall) begin
        raster_apply(in_opcode, in_start_x, in_start_y, in_end_x, in_end_y, in_line_color,
                     emits, pix);
        if (emits) pending_pixels.push_back(row_typed ? row_pix : pix);
      end
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          report_error($sformatf("pixel (%0d,%0d) with nothing expected",
                                 out_pixel_x, out_pixel_y));
        end else begin
          want = pending_pixels.pop_front();
          if (out_pixel_x !== want.x)
            report_error($sformatf("pixel_x got %0d expected %0d", out_pixel_x, want.x));
          if (out_pixel_y !== want.y)
            report_error($sformatf("pixel_y got %0d expected %0d", out_pixel_y, want.y));
          if (out_pixel_address !== want.addr)
            report_error($sformatf("pixel_address got %0d expected %0d",
                                   out_pixel_address, want.addr));
          if (out_pixel_color !== want.color)
            report_error($sformatf("pixel_color got %h expected %h",
                                   out_pixel_color, want.color));
          if (out_write_alpha !== want.alpha)
            report_error($sformatf("write_alpha got %b expected %b",
                                   out_write_alpha, want.alpha));
          if (out_last_pixel !== want.last)
            report_error($sformatf("last_pixel got %b expected %b",
                                   out_last_pixel, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("bresenham_line_rasterizer_core_tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver back-pressure, switching between calm, light, heavy and long runs
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_left % 16) > 5;
    endcase
  end

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_item(input logic op, input logic [CW-1:0] sx, sy, ex, ey,
                           input logic [blr_pkg::COLOR_W-1:0] col, input bit typed,
                           input pixel_t tpix);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    in_line_color <= col;
    row_typed <= typed;
    row_pix <= tpix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    pace();
  endtask

  task automatic issue(input logic op, input logic [CW-1:0] sx, sy, ex, ey,
                       input logic [blr_pkg::COLOR_W-1:0] col);
    items_done++;
    send_item(op, sx, sy, ex, ey, col, 1'b0, '0);
  endtask

  task automatic random_step();
    issue(blr_pkg::OP_STEP, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
          $urandom);
  endtask

  task automatic write_reg(input logic [blr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [blr_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CW-1:0] nearby(input logic [CW-1:0] c);
    int d, v;
    d = int'($urandom_range(0, 16)) - 8;
    v = int'(c) + d;
    if (v < 0 || v > (1 << CW) - 1) v = int'(c) - d;
    return CW'(v);
  endfunction

  function automatic logic [blr_pkg::COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t mk_row(input logic op, input logic [CW-1:0] sx, sy, ex, ey,
                                  input logic [blr_pkg::COLOR_W-1:0] col, input bit typed,
                                  input logic [CW-1:0] px, py,
                                  input logic [blr_pkg::ADDR_W-1:0] addr,
                                  input logic last);
    row_t r;
    r.op = op;
    r.sx = sx;
    r.sy = sy;
    r.ex = ex;
    r.ey = ey;
    r.color = col;
    r.typed = typed;
    r.pix.x = px;
    r.pix.y = py;
    r.pix.addr = addr;
    r.pix.color = col;
    r.pix.alpha = 1'b0;
    r.pix.last = last;
    return r;
  endfunction

  initial begin
    row_t                           directed[$];
    int                             phase, n, kind;
    logic [CW-1:0]                  sx, sy, ex, ey;
    logic [blr_pkg::CFG_DATA_W-1:0] pitch_val, bpp_word;
    logic [blr_pkg::BPP_W-1:0]      bpp_val;

    // reset config: pitch 3072, 3 bytes per pixel
    directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(blr_pkg::OP_START, 0, 0, 3, 0, 32'h11223344, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 32'h11223344, 1, 0, 0, 0, 0));
    directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 32'h11223344, 1, 1, 0, 3, 0));
    directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 32'h11223344, 1, 2, 0, 6, 1));
    directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(blr_pkg::OP_START, 4095, 4095, 4095, 4094, 32'hffffffff,
                              0, 0, 0, 0, 0));
    directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 32'hffffffff, 1, 4095, 4095,
                              26'd12592125, 1));
    // zero-length line
    directed.push_back(mk_row(blr_pkg::OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(blr_pkg::OP_START, 4095, 0, 0, 4095, 32'ha5a5a5a5,
                              0, 0, 0, 0, 0));
    directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 32'ha5a5a5a5, 1, 4095, 0,
                              26'd12285, 0));
    directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // restart while a line is still active
    directed.push_back(mk_row(blr_pkg::OP_START, 10, 20, 13, 27, 32'h5a5a5a5a,
                              0, 0, 0, 0, 0));
    repeat (8) directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(blr_pkg::OP_START, 100, 50, 90, 50, 32'h00ff00ff,
                              0, 0, 0, 0, 0));
    repeat (2) directed.push_back(mk_row(blr_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i])
      send_item(directed[i].op, directed[i].sx, directed[i].sy, directed[i].ex,
                directed[i].ey, directed[i].color, directed[i].typed, directed[i].pix);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0:       begin pitch_val = 0;     bpp_val = 4; end
        1:       begin pitch_val = 16384; bpp_val = 3; end
        2:       begin pitch_val = 32767; bpp_val = 7; end
        3:       begin
          pitch_val = blr_pkg::CFG_DATA_W'($urandom_range(0, 16384));
          bpp_val = 4;
        end
        4:       begin pitch_val = 1;     bpp_val = 0; end
        default: begin
          pitch_val = blr_pkg::CFG_DATA_W'($urandom);
          bpp_val = blr_pkg::BPP_W'($urandom);
        end
      endcase
      bpp_word = blr_pkg::CFG_DATA_W'($urandom);
      bpp_word[blr_pkg::BPP_W-1:0] = bpp_val;
      write_reg(blr_pkg::CFG_ROW_PITCH, pitch_val);
      write_reg(blr_pkg::CFG_BPP, bpp_word);
      items_done = 0;
      while (items_done < ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 9);
        sx = CW'($urandom);
        sy = CW'($urandom);
        if (kind <= 6) begin
          issue(blr_pkg::OP_START, sx, sy, nearby(sx), nearby(sy), pick_color());
          n = 0;
          while (line_busy && n < 40 && $urandom_range(0, 19) != 0) begin
            random_step();
            n++;
          end
          if ($urandom_range(0, 3) == 0) random_step();
        end else if (kind == 7) begin
          ex = CW'($urandom);
          ey = CW'($urandom);
          issue(blr_pkg::OP_START, sx, sy, ex, ey, pick_color());
          n = $urandom_range(1, 30);
          while (line_busy && n > 0) begin
            random_step();
            n--;
          end
        end else if (kind == 8) begin
          issue(blr_pkg::OP_START, sx, sy, sx, sy, pick_color());
          random_step();
        end else begin
          random_step();
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("bresenham_line_rasterizer_core_tb OK");
    else
      $display("bresenham_line_rasterizer_core_tb NOT OK");
    $finish;
  end

endmodule
